// ----- rtl/qtgc_pkg.sv -----
// Package holding the codes, types and grammar tables of the query token grammar checker.
package qtgc_pkg;

  localparam logic [4:0] TK_SELECT  = 5'd0;
  localparam logic [4:0] TK_PUT     = 5'd1;
  localparam logic [4:0] TK_DELETE  = 5'd2;
  localparam logic [4:0] TK_CREATE  = 5'd3;
  localparam logic [4:0] TK_DROP    = 5'd4;
  localparam logic [4:0] TK_ADD     = 5'd5;
  localparam logic [4:0] TK_REMOVE  = 5'd6;
  localparam logic [4:0] TK_DATA    = 5'd7;
  localparam logic [4:0] TK_COUNT   = 5'd8;
  localparam logic [4:0] TK_AVG     = 5'd9;
  localparam logic [4:0] TK_SUM     = 5'd10;
  localparam logic [4:0] TK_MIN     = 5'd11;
  localparam logic [4:0] TK_MAX     = 5'd12;
  localparam logic [4:0] TK_FROM    = 5'd13;
  localparam logic [4:0] TK_INTO    = 5'd14;
  localparam logic [4:0] TK_TAGS    = 5'd15;
  localparam logic [4:0] TK_TABLE   = 5'd16;
  localparam logic [4:0] TK_TO      = 5'd17;
  localparam logic [4:0] TK_ALL     = 5'd18;
  localparam logic [4:0] TK_BETWEEN = 5'd19;
  localparam logic [4:0] TK_AT      = 5'd20;
  localparam logic [4:0] TK_AND     = 5'd21;
  localparam logic [4:0] TK_WHERE   = 5'd22;
  localparam logic [4:0] TK_COMMA   = 5'd23;
  localparam logic [4:0] TK_EQUAL   = 5'd24;
  localparam logic [4:0] TK_SEMI    = 5'd25;
  localparam logic [4:0] TK_IDENT   = 5'd26;
  localparam logic [4:0] TK_NUMBER  = 5'd27;
  localparam logic [4:0] TK_EOF     = 5'd28;

  localparam logic [4:0] EXP_NONE       = 5'd0;
  localparam logic [4:0] EXP_QUERY_WORD = 5'd29;
  localparam logic [4:0] EXP_SEL_TYPE   = 5'd30;
  localparam logic [4:0] EXP_SEL_CLAUSE = 5'd31;

  localparam logic [3:0] ROLE_KEYWORD   = 4'd0;
  localparam logic [3:0] ROLE_METRIC    = 4'd1;
  localparam logic [3:0] ROLE_TABLE     = 4'd2;
  localparam logic [3:0] ROLE_TAG_KEY   = 4'd3;
  localparam logic [3:0] ROLE_TAG_VALUE = 4'd4;
  localparam logic [3:0] ROLE_STAMP     = 4'd5;
  localparam logic [3:0] ROLE_START     = 4'd6;
  localparam logic [3:0] ROLE_END       = 4'd7;
  localparam logic [3:0] ROLE_VALUE     = 4'd8;
  localparam logic [3:0] ROLE_SEL_TYPE  = 4'd9;
  localparam logic [3:0] ROLE_QUERY_END = 4'd10;
  localparam logic [3:0] ROLE_INPUT_END = 4'd11;

  localparam logic [2:0] QK_NONE = 3'd7;

  localparam logic [5:0] POS_START      = 6'd0;
  localparam logic [5:0] POS_AFTER_SEMI = 6'd1;
  localparam logic [5:0] POS_COUNT      = 6'd41;
  localparam logic [5:0] POS_QUERY_END  = 6'd63;

  typedef enum logic [2:0] {
    ST_RUN  = 3'b001,
    ST_FAIL = 3'b010,
    ST_DONE = 3'b100
  } status_e;

  typedef struct packed {
    logic [5:0] pos;
    logic [2:0] query;
    status_e    status;
  } gstate_t;

  typedef struct packed {
    logic       accepted;
    logic [2:0] query_kind;
    logic [3:0] token_role;
    logic       syntax_error;
    logic [4:0] expected_class;
    logic       parse_done;
  } result_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] role;
    logic [5:0] next;
  } rule_t;

  localparam gstate_t GSTATE_RESET = '{pos: POS_START, query: QK_NONE, status: ST_RUN};

  function automatic rule_t rule_lookup(input logic [5:0] pos, input logic [4:0] tok);
    rule_t r;
    r = '{hit: 1'b0, role: ROLE_KEYWORD, next: POS_START};
    case (pos)
      6'd0: begin
        case (tok)
          TK_SELECT: r = '{1'b1, ROLE_KEYWORD, 6'd2};
          TK_PUT:    r = '{1'b1, ROLE_KEYWORD, 6'd16};
          TK_DELETE: r = '{1'b1, ROLE_KEYWORD, 6'd22};
          TK_CREATE: r = '{1'b1, ROLE_KEYWORD, 6'd26};
          TK_DROP:   r = '{1'b1, ROLE_KEYWORD, 6'd31};
          TK_ADD:    r = '{1'b1, ROLE_KEYWORD, 6'd34};
          TK_REMOVE: r = '{1'b1, ROLE_KEYWORD, 6'd38};
          default:   r.hit = 1'b0;
        endcase
      end
      6'd2: begin
        case (tok) inside
          TK_DATA, TK_COUNT, TK_AVG, TK_SUM, TK_MIN, TK_MAX:
            r = '{1'b1, ROLE_SEL_TYPE, 6'd3};
          default: r.hit = 1'b0;
        endcase
      end
      6'd3:  if (tok == TK_IDENT)  r = '{1'b1, ROLE_METRIC, 6'd4};
      6'd4:  if (tok == TK_FROM)   r = '{1'b1, ROLE_KEYWORD, 6'd5};
      6'd5:  if (tok == TK_IDENT)  r = '{1'b1, ROLE_TABLE, 6'd6};
      6'd6: begin
        case (tok)
          TK_ALL:     r = '{1'b1, ROLE_KEYWORD, 6'd11};
          TK_BETWEEN: r = '{1'b1, ROLE_KEYWORD, 6'd7};
          TK_AT:      r = '{1'b1, ROLE_KEYWORD, 6'd10};
          default:    r.hit = 1'b0;
        endcase
      end
      6'd7:  if (tok == TK_NUMBER) r = '{1'b1, ROLE_START, 6'd8};
      6'd8:  if (tok == TK_AND)    r = '{1'b1, ROLE_KEYWORD, 6'd9};
      6'd9:  if (tok == TK_NUMBER) r = '{1'b1, ROLE_END, 6'd11};
      6'd10: if (tok == TK_NUMBER) r = '{1'b1, ROLE_STAMP, 6'd11};
      6'd11: begin
        if (tok == TK_WHERE)     r = '{1'b1, ROLE_KEYWORD, 6'd12};
        else if (tok == TK_SEMI) r = '{1'b1, ROLE_QUERY_END, POS_QUERY_END};
      end
      6'd12: if (tok == TK_IDENT)  r = '{1'b1, ROLE_TAG_KEY, 6'd13};
      6'd13: if (tok == TK_EQUAL)  r = '{1'b1, ROLE_KEYWORD, 6'd14};
      6'd14: if (tok == TK_IDENT)  r = '{1'b1, ROLE_TAG_VALUE, 6'd15};
      6'd15: begin
        if (tok == TK_COMMA)     r = '{1'b1, ROLE_KEYWORD, 6'd12};
        else if (tok == TK_SEMI) r = '{1'b1, ROLE_QUERY_END, POS_QUERY_END};
      end
      6'd16: if (tok == TK_IDENT)  r = '{1'b1, ROLE_METRIC, 6'd17};
      6'd17: if (tok == TK_NUMBER) r = '{1'b1, ROLE_STAMP, 6'd18};
      6'd18: if (tok == TK_NUMBER) r = '{1'b1, ROLE_VALUE, 6'd19};
      6'd19: if (tok == TK_INTO)   r = '{1'b1, ROLE_KEYWORD, 6'd20};
      6'd20: if (tok == TK_IDENT)  r = '{1'b1, ROLE_TABLE, 6'd21};
      6'd21: begin
        if (tok == TK_TAGS)      r = '{1'b1, ROLE_KEYWORD, 6'd12};
        else if (tok == TK_SEMI) r = '{1'b1, ROLE_QUERY_END, POS_QUERY_END};
      end
      6'd22: if (tok == TK_IDENT)  r = '{1'b1, ROLE_METRIC, 6'd23};
      6'd23: if (tok == TK_NUMBER) r = '{1'b1, ROLE_STAMP, 6'd24};
      6'd24: if (tok == TK_FROM)   r = '{1'b1, ROLE_KEYWORD, 6'd25};
      6'd25: if (tok == TK_IDENT)  r = '{1'b1, ROLE_TABLE, 6'd21};
      6'd26: if (tok == TK_TABLE)  r = '{1'b1, ROLE_KEYWORD, 6'd27};
      6'd27: if (tok == TK_IDENT)  r = '{1'b1, ROLE_TABLE, 6'd28};
      6'd28: begin
        if (tok == TK_TAGS)      r = '{1'b1, ROLE_KEYWORD, 6'd29};
        else if (tok == TK_SEMI) r = '{1'b1, ROLE_QUERY_END, POS_QUERY_END};
      end
      6'd29: if (tok == TK_IDENT)  r = '{1'b1, ROLE_TAG_KEY, 6'd30};
      6'd30: begin
        if (tok == TK_COMMA)     r = '{1'b1, ROLE_KEYWORD, 6'd29};
        else if (tok == TK_SEMI) r = '{1'b1, ROLE_QUERY_END, POS_QUERY_END};
      end
      6'd31: if (tok == TK_TABLE)  r = '{1'b1, ROLE_KEYWORD, 6'd32};
      6'd32: if (tok == TK_IDENT)  r = '{1'b1, ROLE_TABLE, 6'd33};
      6'd33: if (tok == TK_SEMI)   r = '{1'b1, ROLE_QUERY_END, POS_QUERY_END};
      6'd34: if (tok == TK_TAGS)   r = '{1'b1, ROLE_KEYWORD, 6'd35};
      6'd35: if (tok == TK_IDENT)  r = '{1'b1, ROLE_TAG_KEY, 6'd36};
      6'd36: begin
        if (tok == TK_COMMA)   r = '{1'b1, ROLE_KEYWORD, 6'd35};
        else if (tok == TK_TO) r = '{1'b1, ROLE_KEYWORD, 6'd37};
      end
      6'd37: if (tok == TK_IDENT)  r = '{1'b1, ROLE_TABLE, 6'd33};
      6'd38: if (tok == TK_TAGS)   r = '{1'b1, ROLE_KEYWORD, 6'd39};
      6'd39: if (tok == TK_IDENT)  r = '{1'b1, ROLE_TAG_KEY, 6'd40};
      6'd40: begin
        if (tok == TK_COMMA)     r = '{1'b1, ROLE_KEYWORD, 6'd39};
        else if (tok == TK_FROM) r = '{1'b1, ROLE_KEYWORD, 6'd37};
      end
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] expect_lookup(input logic [5:0] pos);
    logic [4:0] e;
    case (pos) inside
      6'd0, 6'd1: e = EXP_QUERY_WORD;
      6'd2:       e = EXP_SEL_TYPE;
      6'd6:       e = EXP_SEL_CLAUSE;
      6'd3, 6'd5, 6'd12, 6'd14, 6'd16, 6'd20, 6'd22, 6'd25, 6'd27, 6'd29, 6'd32, 6'd35,
      6'd37, 6'd39:
                  e = TK_IDENT;
      6'd7, 6'd9, 6'd10, 6'd17, 6'd18, 6'd23:
                  e = TK_NUMBER;
      6'd11, 6'd15, 6'd21, 6'd28, 6'd30, 6'd33:
                  e = TK_SEMI;
      6'd4, 6'd24, 6'd40:
                  e = TK_FROM;
      6'd8:       e = TK_AND;
      6'd13:      e = TK_EQUAL;
      6'd19:      e = TK_INTO;
      6'd26, 6'd31:
                  e = TK_TABLE;
      6'd34, 6'd38:
                  e = TK_TAGS;
      6'd36:      e = TK_TO;
      default:    e = EXP_QUERY_WORD;
    endcase
    return e;
  endfunction

endpackage

// ----- rtl/qtgc_tok_if.sv -----
// Handshake interface carrying token words into the checker.
interface qtgc_tok_if;
  logic       valid;
  logic       ready;
  logic [4:0] token_kind;
  logic       stream_end;

  modport source (output valid, output token_kind, output stream_end, input ready);
  modport sink (input valid, input token_kind, input stream_end, output ready);
endinterface

// ----- rtl/qtgc_res_if.sv -----
// Handshake interface carrying result words out of the checker.
interface qtgc_res_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic [2:0] query_kind;
  logic [3:0] token_role;
  logic       syntax_error;
  logic [4:0] expected_class;
  logic       parse_done;

  modport source (output valid, output accepted, output query_kind, output token_role,
                  output syntax_error, output expected_class, output parse_done,
                  input ready);
  modport sink (input valid, input accepted, input query_kind, input token_role,
                input syntax_error, input expected_class, input parse_done,
                output ready);
endinterface

// ----- rtl/qtgc_step.sv -----
// Combinational grammar step: next parser state and result word for one token.
module qtgc_step (
  input  qtgc_pkg::gstate_t state_i,
  input  logic [4:0]        token_kind_i,
  input  logic              stream_end_i,
  output qtgc_pkg::gstate_t state_o,
  output qtgc_pkg::result_t result_o
);
  import qtgc_pkg::*;

  logic [5:0] pos;
  logic [5:0] pos_eff;
  rule_t      rule;
  logic [2:0] kind;

  assign pos     = (state_i.pos >= POS_COUNT) ? POS_START : state_i.pos;
  assign pos_eff = (pos == POS_AFTER_SEMI) ? POS_START : pos;
  assign rule    = rule_lookup(pos_eff, token_kind_i);
  assign kind    = (pos_eff == POS_START) ? token_kind_i[2:0] : state_i.query;

  always_comb begin
    result_o = '{accepted: 1'b0, query_kind: state_i.query, token_role: ROLE_KEYWORD,
                 syntax_error: 1'b0, expected_class: EXP_NONE, parse_done: 1'b0};
    state_o  = state_i;
    unique case (state_i.status)
      ST_DONE: begin
        result_o.query_kind = QK_NONE;
        result_o.parse_done = 1'b1;
        if (stream_end_i) state_o = GSTATE_RESET;
      end
      ST_FAIL: begin
        if (stream_end_i) state_o = GSTATE_RESET;
      end
      ST_RUN: begin
        if (stream_end_i) begin
          if (pos == POS_AFTER_SEMI) begin
            result_o.accepted   = 1'b1;
            result_o.query_kind = QK_NONE;
            result_o.token_role = ROLE_INPUT_END;
            result_o.parse_done = 1'b1;
          end else begin
            result_o.syntax_error   = 1'b1;
            result_o.expected_class = expect_lookup(pos);
          end
          state_o = GSTATE_RESET;
        end else if (pos == POS_AFTER_SEMI && token_kind_i == TK_EOF) begin
          result_o.accepted   = 1'b1;
          result_o.query_kind = QK_NONE;
          result_o.token_role = ROLE_INPUT_END;
          result_o.parse_done = 1'b1;
          state_o.status      = ST_DONE;
        end else if (rule.hit) begin
          result_o.accepted   = 1'b1;
          result_o.query_kind = kind;
          result_o.token_role = rule.role;
          if (rule.next == POS_QUERY_END) begin
            state_o.query = QK_NONE;
            state_o.pos   = POS_AFTER_SEMI;
          end else begin
            state_o.query = kind;
            state_o.pos   = rule.next;
          end
        end else begin
          result_o.syntax_error   = 1'b1;
          result_o.expected_class = expect_lookup(pos_eff);
          state_o.pos             = pos_eff;
          state_o.status          = ST_FAIL;
        end
      end
      default: state_o = GSTATE_RESET;
    endcase
  end

endmodule

// ----- rtl/query_token_grammar_checker.sv -----
// Top level of the query token grammar checker.
// The block takes one token word per handshake on tok_i and returns one result word
// per token on res_o, in order. A token word names a token code, or marks the end of
// the stream with stream_end set. The result word gives the role of the token, the
// query it belongs to, a syntax error with the expected class, and completion.
// A token word is first held in an input register; when the result register is free,
// the grammar step is evaluated against the parser state and written to the result
// register. The result word is valid once it has passed both registers. One token
// word is accepted every cycle while res_o is not stalled.
// When res_o stalls, the result is held; one further word may wait in the input
// register, and then tok_i.ready falls until the result word is taken.
// Reset empties both registers and returns the parser to the start of a query,
// with no current query and the running status. A stream-end word also returns
// the parser to that state once its result has been formed.
module query_token_grammar_checker (
  input logic       clk_i,
  input logic       rst_ni,
  qtgc_tok_if.sink  tok_i,
  qtgc_res_if.source res_o
);
  import qtgc_pkg::*;

  logic       s1_valid_q, s1_valid_d;
  logic [4:0] s1_tok_q;
  logic       s1_end_q;
  logic       out_valid_q, out_valid_d;
  result_t    res_q;
  gstate_t    state_q;
  gstate_t    step_state;
  result_t    step_res;
  logic       in_take;
  logic       out_free;
  logic       s1_adv;

  assign out_free    = !out_valid_q || res_o.ready;
  assign s1_adv      = s1_valid_q && out_free;
  assign tok_i.ready = !s1_valid_q || out_free;
  assign in_take     = tok_i.valid && tok_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) s1_valid_d = 1'b1;
    else if (s1_adv) s1_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (s1_adv) out_valid_d = 1'b1;
    else if (res_o.ready) out_valid_d = 1'b0;
  end

  qtgc_step u_step (
    .state_i      (state_q),
    .token_kind_i (s1_tok_q),
    .stream_end_i (s1_end_q),
    .state_o      (step_state),
    .result_o     (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= GSTATE_RESET;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_adv) state_q <= step_state;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_tok_q <= tok_i.token_kind;
      s1_end_q <= tok_i.stream_end;
    end
    if (s1_adv) res_q <= step_res;
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.accepted       = res_q.accepted;
  assign res_o.query_kind     = res_q.query_kind;
  assign res_o.token_role     = res_q.token_role;
  assign res_o.syntax_error   = res_q.syntax_error;
  assign res_o.expected_class = res_q.expected_class;
  assign res_o.parse_done     = res_q.parse_done;

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |-> (!s1_valid_q || s1_adv))
    else $error("token word accepted while the input register could not drain");

  a_error_fails: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && !s1_end_q && step_res.syntax_error) |=> (state_q.status == ST_FAIL))
    else $error("syntax error did not leave the parser in the failed status");

  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_end_q) |=>
      (state_q.pos == POS_START && state_q.status == ST_RUN && state_q.query == QK_NONE))
    else $error("stream end did not return the parser to its reset state");

  a_done_is_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.parse_done) |-> (res_q.query_kind == QK_NONE && !res_q.syntax_error))
    else $error("completion word carries a query or an error");

endmodule
